/* design/mmlrm_pkg.sv */
// ============================================================================
// Memory-map line range matcher package
// Shared word types, result codes and the hex digit decoder.
// ============================================================================
`default_nettype none

package mmlrm_pkg;

    localparam int LINE_CAP_DEF = 512;
    localparam int PATH_CAP_DEF = 63;

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 6;   // pathname length, also max_path_chars width
    localparam int IDX_W  = 2;   // config register index

    // config register indexes
    localparam logic [IDX_W-1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_PATH_CHARS = 2'd1;

    // result status codes
    localparam logic [1:0] ST_CHAR     = 2'd0;
    localparam logic [1:0] ST_FOUND    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // input request codes
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOD  = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        path_char;
        logic [ADDR_W-1:0] base_address;
        logic              last;
    } t_out_word;

    // front to back command
    typedef struct packed {
        logic              is_found;
        logic [LEN_W-1:0]  path_len;
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] map_offset;
    } t_cmd;

    // {valid, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/mmlrm_ram.sv */
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mmlrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/mmlrm_cmdq.sv */
// ============================================================================
// Command queue
// Two-entry queue carrying commands from the parser to the emitter.
// ============================================================================
`default_nettype none

module mmlrm_cmdq import mmlrm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/mmlrm_front.sv */
// ============================================================================
// Line parser
// Parses listing bytes, stores the pathname, issues found/not-found commands.
// ============================================================================
`default_nettype none

module mmlrm_front import mmlrm_pkg::*; #(
    parameter int LINE_CAP = LINE_CAP_DEF,
    parameter int PATH_CAP = PATH_CAP_DEF,
    parameter int AW       = (PATH_CAP > 1) ? $clog2(PATH_CAP) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  t_in_word               i_word,
    input  wire logic [ADDR_W-1:0] i_target_address,
    input  wire logic [LEN_W-1:0]  i_max_path_chars,
    input  wire logic              i_found_done,
    output logic                   o_lock,
    output logic                   o_cmd_push,
    output t_cmd                   o_cmd,
    output logic                   o_wr_en,
    output logic      [AW-1:0]     o_wr_addr,
    output logic      [7:0]        o_wr_data
);

    localparam int LC_W = $clog2(LINE_CAP);
    localparam logic [LC_W-1:0]  LINE_MAX = LC_W'(LINE_CAP - 1);
    localparam logic [LEN_W-1:0] PCAP     = LEN_W'(PATH_CAP);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_END    = 3'd1;
    localparam logic [2:0] PH_FIELDS = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_PATH   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]        r_phase,       n_phase;
    logic [LC_W-1:0]   r_line_count,  n_line_count;
    logic [ADDR_W-1:0] r_range_start, n_range_start;
    logic [ADDR_W-1:0] r_range_end,   n_range_end;
    logic [ADDR_W-1:0] r_map_offset,  n_map_offset;
    logic [2:0]        r_spaces_seen, n_spaces_seen;
    logic [LEN_W-1:0]  r_path_length, n_path_length;
    logic              r_lock,        n_lock;

    logic [4:0]       hex;
    logic [7:0]       c;
    logic [LEN_W-1:0] lim;
    logic             hit;
    logic             keep;

    assign c   = i_word.data_byte;
    assign hex = hex_digit(c);
    assign lim = (i_max_path_chars > PCAP) ? PCAP : i_max_path_chars;
    assign hit = (i_target_address >= r_range_start) && (i_target_address < r_range_end);

    assign o_lock    = r_lock;
    assign o_wr_addr = r_path_length[AW-1:0];
    assign o_wr_data = c;

    always_comb begin
        n_phase       = r_phase;
        n_line_count  = r_line_count;
        n_range_start = r_range_start;
        n_range_end   = r_range_end;
        n_map_offset  = r_map_offset;
        n_spaces_seen = r_spaces_seen;
        n_path_length = r_path_length;
        n_lock        = r_lock && !i_found_done;
        o_cmd_push    = 1'b0;
        o_cmd         = '{is_found: 1'b0, path_len: r_path_length,
                          range_start: r_range_start, map_offset: r_map_offset};
        keep          = 1'b0;

        if (i_accept) begin
            if (i_word.req_type == REQ_EOD || c == CH_NL) begin
                // end of line or data: drop parse state
                n_phase       = PH_START;
                n_line_count  = '0;
                n_range_start = '0;
                n_range_end   = '0;
                n_map_offset  = '0;
                n_spaces_seen = '0;
                n_path_length = '0;
            end
            if (i_word.req_type == REQ_EOD) begin
                o_cmd_push = (r_phase != PH_DONE);
            end else if (r_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (c == CH_NL) begin
                if (hit && r_phase == PH_PATH) begin
                    o_cmd_push     = 1'b1;
                    o_cmd.is_found = 1'b1;
                    n_phase        = PH_DONE;
                    n_lock         = 1'b1;
                end
            end else if (r_line_count < LINE_MAX) begin
                n_line_count = r_line_count + 1'b1;
                case (r_phase)
                    PH_START: begin
                        if (c == CH_DASH) begin
                            n_phase = PH_END;
                        end else if (hex[4]) begin
                            n_range_start = {r_range_start[ADDR_W-5:0], hex[3:0]};
                        end
                    end
                    PH_END: begin
                        if (c == CH_SPACE) begin
                            n_spaces_seen = 3'd1;
                            n_phase       = PH_FIELDS;
                        end else if (hex[4]) begin
                            n_range_end = {r_range_end[ADDR_W-5:0], hex[3:0]};
                        end
                    end
                    PH_FIELDS: begin
                        if (c == CH_SPACE) begin
                            n_spaces_seen = r_spaces_seen + 3'd1;
                            if (r_spaces_seen >= 3'd4) begin
                                n_phase = PH_SKIP;
                            end
                        end else if (r_spaces_seen == 3'd2 && hex[4]) begin
                            n_map_offset = {r_map_offset[ADDR_W-5:0], hex[3:0]};
                        end
                    end
                    PH_SKIP: begin
                        if (c != CH_SPACE) begin
                            n_phase = PH_PATH;
                            keep    = 1'b1;
                        end
                    end
                    PH_PATH: begin
                        keep = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (keep && r_path_length < lim) begin
                    n_path_length = r_path_length + 1'b1;
                end
            end
        end
    end

    assign o_wr_en = keep && (r_path_length < lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_line_count  <= '0;
            r_range_start <= '0;
            r_range_end   <= '0;
            r_map_offset  <= '0;
            r_spaces_seen <= '0;
            r_path_length <= '0;
            r_lock        <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_line_count  <= n_line_count;
            r_range_start <= n_range_start;
            r_range_end   <= n_range_end;
            r_map_offset  <= n_map_offset;
            r_spaces_seen <= n_spaces_seen;
            r_path_length <= n_path_length;
            r_lock        <= n_lock;
        end
    end

`ifndef SYNTHESIS
    // a found burst is outstanding only while the parser sits in done
    a_lock_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> (r_phase == PH_DONE))
        else $error("lock held outside done phase");
    // pathname never grows past the store
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_path_length <= PCAP)
        else $error("path length past capacity");
`endif

endmodule

`default_nettype wire

/* design/mmlrm_back.sv */
// ============================================================================
// Result emitter
// Replays the stored pathname and closes each search with found/not-found.
// ============================================================================
`default_nettype none

module mmlrm_back import mmlrm_pkg::*; #(
    parameter int PATH_CAP = PATH_CAP_DEF,
    parameter int AW       = (PATH_CAP > 1) ? $clog2(PATH_CAP) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_found_done,
    output logic               o_rd_en,
    output logic      [AW-1:0] o_rd_addr,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_empty,
    input  wire logic          i_pop,
    output t_out_word          o_word
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_CHARS = 2'd1;
    localparam logic [1:0] B_FINAL = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_idx,   n_idx;
    logic             r_rd_inflight;
    logic             r_out_valid;
    t_out_word        r_out;

    logic out_free, fin_en;

    assign out_free  = !r_out_valid || i_pop;
    assign o_rd_addr = r_idx[AW-1:0];
    assign o_empty   = !r_out_valid;
    assign o_word    = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_rd_en      = 1'b0;
        fin_en       = 1'b0;
        o_cmd_pop    = 1'b0;
        o_found_done = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    n_idx = '0;
                    if (i_cmd.is_found && i_cmd.path_len != '0) begin
                        n_state = B_CHARS;
                    end else begin
                        n_state = B_FINAL;
                    end
                end
            end
            B_CHARS: begin
                o_rd_en = !r_rd_inflight && out_free;
                if (o_rd_en) begin
                    if (r_idx == i_cmd.path_len - 1'b1) begin
                        n_state = B_FINAL;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            B_FINAL: begin
                fin_en = !r_rd_inflight && out_free;
                if (fin_en) begin
                    o_cmd_pop    = 1'b1;
                    o_found_done = i_cmd.is_found;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_idx         <= '0;
            r_rd_inflight <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_rd_inflight <= o_rd_en;
            if (r_rd_inflight || fin_en) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_inflight) begin
            r_out <= '{status: ST_CHAR, path_char: i_rd_data,
                       base_address: '0, last: 1'b0};
        end else if (fin_en) begin
            r_out <= '{status: i_cmd.is_found ? ST_FOUND : ST_NOTFOUND,
                       path_char: 8'd0,
                       base_address: i_cmd.is_found
                           ? (i_cmd.range_start - i_cmd.map_offset) : '0,
                       last: 1'b1};
        end
    end

`ifndef SYNTHESIS
    // read data always lands in an empty output slot
    a_rd_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_inflight |-> !r_out_valid)
        else $error("read data would overwrite pending word");
    // char replay only for a found command with a pathname
    a_chars_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CHARS) |-> (i_cmd_valid && i_cmd.is_found && i_cmd.path_len != '0))
        else $error("char replay without found command");
    // last marks exactly the closing words
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == (r_out.status != ST_CHAR)))
        else $error("last flag mismatch");
`endif

endmodule

`default_nettype wire

/* design/memory_map_line_range_matcher_top.sv */
// Order: a found word follows its newline after the emitter replays each pathname char
//   (one path RAM read and one output load each); not-found follows end of data.
// Throughput: one listing byte per cycle; input stalls (full) from a match until its
//   found word is loaded into the emitter output, and when the command queue fills.
// Reset: synchronous, active low; clears parse state, queue, emitter and config
//   (target 0, max chars 63). The path RAM is not cleared and needs no sweep.
// ============================================================================
// Memory-map line range matcher
// Parser front end, two-entry command queue, pathname RAM and result emitter.
// ============================================================================
`default_nettype none

module memory_map_line_range_matcher_top import mmlrm_pkg::*; #(
    parameter int LINE_CAP = LINE_CAP_DEF,
    parameter int PATH_CAP = PATH_CAP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input word queue side
    input  wire logic              push,
    output logic                   full,
    input  t_in_word               i_in_word,
    // result word queue side
    output logic                   empty,
    input  wire logic              pop,
    output t_out_word              o_out_word,
    // config write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [ADDR_W-1:0] i_cfg_data
);

    localparam int AW = (PATH_CAP > 1) ? $clog2(PATH_CAP) : 1;

    logic [ADDR_W-1:0] r_target_address;
    logic [LEN_W-1:0]  r_max_path_chars;

    // front <-> queue <-> back
    logic    accept;
    logic    lock;
    logic    cmd_push, cmd_full, cmd_valid, cmd_pop;
    t_cmd    cmd_in, cmd_head;
    logic    found_done;

    // path RAM ports
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    // Always ready; user must change config only while the block is idle (unenforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= '0;
            r_max_path_chars <= LEN_W'(63);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_ADDRESS: r_target_address <= i_cfg_data;
                CFG_MAX_PATH_CHARS: r_max_path_chars <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold input while the queue is full or a pathname burst is pending, so
    // the next line cannot overwrite path RAM entries still being replayed.
    assign full   = cmd_full || lock;
    assign accept = push && !full;

    mmlrm_front #(
        .LINE_CAP (LINE_CAP),
        .PATH_CAP (PATH_CAP),
        .AW       (AW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_word           (i_in_word),
        .i_target_address (r_target_address),
        .i_max_path_chars (r_max_path_chars),
        .i_found_done     (found_done),
        .o_lock           (lock),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data)
    );

    mmlrm_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    // Pathname store: written by the parser, read back by the emitter.
    mmlrm_ram #(
        .WIDTH (8),
        .DEPTH (PATH_CAP),
        .AW    (AW)
    ) u_path_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mmlrm_back #(
        .PATH_CAP (PATH_CAP),
        .AW       (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .o_found_done (found_done),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_word       (o_out_word)
    );

`ifndef SYNTHESIS
    // parser never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire
